[rtl/wttd_pkg.sv]
// Shared types, constants and the arctangent table of the waypoint follower.
// Used by the datapath, controller, top level, checker and testbench; depends on nothing.
package wttd_pkg;

   localparam int FIFO_DEPTH   = 16;
   localparam int CORDIC_STEPS = 16;

   localparam int FIFO_AW  = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int COUNT_W  = $clog2(FIFO_DEPTH + 1);
   localparam int STEP_W   = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
   localparam int CORDIC_W = 20;
   localparam int QUEUED_W = 5;
   localparam int PADDR_W  = 5;

   // phase codes
   localparam logic [1:0] PH_IDLE   = 2'd0;
   localparam logic [1:0] PH_COARSE = 2'd1;
   localparam logic [1:0] PH_FINE   = 2'd2;
   localparam logic [1:0] PH_DRIVE  = 2'd3;

   // request kinds
   localparam logic REQ_PUSH = 1'b0;
   localparam logic REQ_TICK = 1'b1;

   // register indexes
   localparam logic [2:0] REG_DRIVE_SPEED = 3'd0;
   localparam logic [2:0] REG_FAST_RATE   = 3'd1;
   localparam logic [2:0] REG_FINE_RATE   = 3'd2;
   localparam logic [2:0] REG_COARSE_TOL  = 3'd3;
   localparam logic [2:0] REG_FINE_TOL    = 3'd4;
   localparam logic [2:0] REG_ARRIVE_RAD  = 3'd5;

   // controller to datapath
   typedef struct packed {
      logic              latch;
      logic              fifo_read;
      logic              load;
      logic              cordic_step;
      logic              cordic_last;
      logic [STEP_W-1:0] step;
      logic              square;
      logic              finish;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_tick;
      logic start_pop;
   } status_type;

   // atan(2^-i) in binary angle units
   function automatic logic [15:0] atan_entry(input logic [4:0] i);
      logic [15:0] v;
      case (i)
         5'd0:    v = 16'd8192;
         5'd1:    v = 16'd4836;
         5'd2:    v = 16'd2555;
         5'd3:    v = 16'd1297;
         5'd4:    v = 16'd651;
         5'd5:    v = 16'd326;
         5'd6:    v = 16'd163;
         5'd7:    v = 16'd81;
         5'd8:    v = 16'd41;
         5'd9:    v = 16'd20;
         5'd10:   v = 16'd10;
         5'd11:   v = 16'd5;
         5'd12:   v = 16'd3;
         5'd13:   v = 16'd1;
         5'd14:   v = 16'd1;
         default: v = 16'd0;
      endcase
      return v;
   endfunction

endpackage

[rtl/wttd_if.sv]
// Valid/ready channel interfaces for requests and responses.
// Depends on nothing.
interface wttd_req_if;
   logic               valid;
   logic               ready;
   logic               req_type;
   logic signed [15:0] pos_x;
   logic signed [15:0] pos_y;
   logic signed [15:0] pose_yaw;
   modport source (output valid, req_type, pos_x, pos_y, pose_yaw, input ready);
   modport sink   (input valid, req_type, pos_x, pos_y, pose_yaw, output ready);
endinterface

interface wttd_rsp_if;
   logic               valid;
   logic               ready;
   logic [15:0]        linear_speed;
   logic signed [16:0] angular_speed;
   logic [1:0]         phase;
   logic               reached;
   logic               dropped;
   logic [4:0]         queued;
   modport source (output valid, linear_speed, angular_speed, phase, reached, dropped,
                   queued, input ready);
   modport sink   (input valid, linear_speed, angular_speed, phase, reached, dropped,
                   queued, output ready);
endinterface

[rtl/wttd_datapath.sv]
// Datapath: config registers, waypoint FIFO, CORDIC atan2, squares and phase logic.
// Depends on wttd_pkg.
module wttd_datapath (
   input  logic                    clock,
   input  logic                    reset,
   input  wttd_pkg::cmd_type       cmd,
   output wttd_pkg::status_type    status,
   // request payload
   input  logic                    in_type,
   input  logic signed [15:0]      in_pos_x,
   input  logic signed [15:0]      in_pos_y,
   input  logic signed [15:0]      in_yaw,
   // csr
   input  logic                    csr_wr,
   input  logic [2:0]              csr_index,
   input  logic [31:0]             csr_wdata,
   output logic [31:0]             csr_rdata,
   // response payload
   output logic [15:0]             out_linear_speed,
   output logic signed [16:0]      out_angular_speed,
   output logic [1:0]              out_phase,
   output logic                    out_reached,
   output logic                    out_dropped,
   output logic [4:0]              out_queued
);
   localparam int CW = wttd_pkg::CORDIC_W;

   // configuration
   logic [15:0] drive_speed_ff, fast_rate_ff, fine_rate_ff, arrive_rad_ff;
   logic [14:0] coarse_tol_ff, fine_tol_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         drive_speed_ff <= 16'd92;
         fast_rate_ff   <= 16'd82;
         fine_rate_ff   <= 16'd20;
         coarse_tol_ff  <= 15'd1043;
         fine_tol_ff    <= 15'd104;
         arrive_rad_ff  <= 16'd410;
      end else if (csr_wr) begin
         unique case (csr_index)
            wttd_pkg::REG_DRIVE_SPEED: drive_speed_ff <= csr_wdata[15:0];
            wttd_pkg::REG_FAST_RATE:   fast_rate_ff   <= csr_wdata[15:0];
            wttd_pkg::REG_FINE_RATE:   fine_rate_ff   <= csr_wdata[15:0];
            wttd_pkg::REG_COARSE_TOL:  coarse_tol_ff  <= csr_wdata[14:0];
            wttd_pkg::REG_FINE_TOL:    fine_tol_ff    <= csr_wdata[14:0];
            wttd_pkg::REG_ARRIVE_RAD:  arrive_rad_ff  <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         wttd_pkg::REG_DRIVE_SPEED: csr_rdata = {16'd0, drive_speed_ff};
         wttd_pkg::REG_FAST_RATE:   csr_rdata = {16'd0, fast_rate_ff};
         wttd_pkg::REG_FINE_RATE:   csr_rdata = {16'd0, fine_rate_ff};
         wttd_pkg::REG_COARSE_TOL:  csr_rdata = {17'd0, coarse_tol_ff};
         wttd_pkg::REG_FINE_TOL:    csr_rdata = {17'd0, fine_tol_ff};
         wttd_pkg::REG_ARRIVE_RAD:  csr_rdata = {16'd0, arrive_rad_ff};
         default:                   csr_rdata = 32'd0;
      endcase
   end

   // latched request
   logic               type_ff;
   logic signed [15:0] px_ff, py_ff, yaw_ff;

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         type_ff <= in_type;
         px_ff   <= in_pos_x;
         py_ff   <= in_pos_y;
         yaw_ff  <= in_yaw;
      end
   end

   // control state
   logic [wttd_pkg::FIFO_AW-1:0] head_ff, tail_ff;
   logic [wttd_pkg::COUNT_W-1:0] count_ff;
   logic signed [15:0]           target_x_ff, target_y_ff;
   logic [15:0]                  heading_ff;
   logic [1:0]                   phase_ff;

   assign status.is_tick   = (type_ff == wttd_pkg::REQ_TICK);
   assign status.start_pop = (phase_ff == wttd_pkg::PH_IDLE) && (count_ff != '0);

   // waypoint memory
   logic [31:0] mem [wttd_pkg::FIFO_DEPTH];
   logic [31:0] rdata_ff;
   logic        fifo_full;
   logic        do_push;

   assign fifo_full = (count_ff == wttd_pkg::COUNT_W'(wttd_pkg::FIFO_DEPTH));
   assign do_push   = cmd.finish && !status.is_tick && !fifo_full;

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[tail_ff] <= {py_ff, px_ff};
      end
      if (cmd.fifo_read) begin
         rdata_ff <= mem[head_ff];
      end
   end

   function automatic logic [wttd_pkg::FIFO_AW-1:0] ptr_next(
      input logic [wttd_pkg::FIFO_AW-1:0] p);
      logic [wttd_pkg::FIFO_AW-1:0] n;
      if (p == wttd_pkg::FIFO_AW'(wttd_pkg::FIFO_DEPTH - 1)) n = '0;
      else n = p + 1'b1;
      return n;
   endfunction

   // CORDIC vectoring
   logic signed [CW-1:0] cx_ff, cy_ff;
   logic [15:0]          cang_ff;
   logic                 czero_ff;
   logic signed [16:0]   ldx, ldy;
   logic signed [CW-1:0] xs, ys, cx_in, cy_in;
   logic [15:0]          cang_in, tab;

   assign ldx = 17'(signed'(rdata_ff[15:0])) - 17'(px_ff);
   assign ldy = 17'(signed'(rdata_ff[31:16])) - 17'(py_ff);
   assign xs  = cx_ff >>> cmd.step;
   assign ys  = cy_ff >>> cmd.step;
   assign tab = wttd_pkg::atan_entry(5'(cmd.step));

   always_comb begin
      if (!cy_ff[CW-1]) begin
         cx_in   = cx_ff + ys;
         cy_in   = cy_ff - xs;
         cang_in = cang_ff + tab;
      end else begin
         cx_in   = cx_ff - ys;
         cy_in   = cy_ff + xs;
         cang_in = cang_ff - tab;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         czero_ff <= (ldx == '0) && (ldy == '0);
         if (ldx[16]) begin
            cx_ff   <= -CW'(ldx);
            cy_ff   <= -CW'(ldy);
            cang_ff <= 16'd32768;
         end else begin
            cx_ff   <= CW'(ldx);
            cy_ff   <= CW'(ldy);
            cang_ff <= 16'd0;
         end
      end else if (cmd.cordic_step) begin
         cx_ff   <= cx_in;
         cy_ff   <= cy_in;
         cang_ff <= cang_in;
      end
   end

   // squared distance and radius
   logic signed [16:0] dx, dy;
   logic [33:0]        sq_x_ff, sq_y_ff;
   logic [31:0]        r2_ff;

   assign dx = 17'(target_x_ff) - 17'(px_ff);
   assign dy = 17'(target_y_ff) - 17'(py_ff);

   always_ff @(posedge clock) begin
      if (cmd.square) begin
         sq_x_ff <= 34'(dx * dx);
         sq_y_ff <= 34'(dy * dy);
         r2_ff   <= arrive_rad_ff * arrive_rad_ff;
      end
   end

   // phase evaluation for a tick
   logic signed [15:0] err;
   logic [15:0]        mag;
   logic [34:0]        d2;
   logic [1:0]         ph;
   logic [15:0]        lin;
   logic signed [16:0] ang;
   logic               reach;

   assign err = signed'(heading_ff - yaw_ff);
   assign mag = err[15] ? 16'(-err) : 16'(err);
   assign d2  = 35'(sq_x_ff) + 35'(sq_y_ff);

   always_comb begin
      ph    = phase_ff;
      lin   = 16'd0;
      ang   = 17'sd0;
      reach = 1'b0;
      if (ph == wttd_pkg::PH_COARSE) begin
         if (mag > {1'b0, coarse_tol_ff})
            ang = err[15] ? -signed'({1'b0, fast_rate_ff}) : signed'({1'b0, fast_rate_ff});
         else
            ph = wttd_pkg::PH_FINE;
      end
      if (ph == wttd_pkg::PH_FINE) begin
         if (mag > {1'b0, fine_tol_ff})
            ang = err[15] ? -signed'({1'b0, fine_rate_ff}) : signed'({1'b0, fine_rate_ff});
         else
            ph = wttd_pkg::PH_DRIVE;
      end
      if (ph == wttd_pkg::PH_DRIVE) begin
         if (d2 > 35'(r2_ff)) begin
            lin = drive_speed_ff;
         end else begin
            reach = 1'b1;
            ph    = wttd_pkg::PH_IDLE;
         end
      end
   end

   // state updates
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff     <= '0;
         tail_ff     <= '0;
         count_ff    <= '0;
         target_x_ff <= '0;
         target_y_ff <= '0;
         heading_ff  <= '0;
         phase_ff    <= wttd_pkg::PH_IDLE;
      end else begin
         if (cmd.fifo_read) begin
            head_ff  <= ptr_next(head_ff);
            count_ff <= count_ff - 1'b1;
            phase_ff <= wttd_pkg::PH_COARSE;
         end
         if (do_push) begin
            tail_ff  <= ptr_next(tail_ff);
            count_ff <= count_ff + 1'b1;
         end
         if (cmd.load) begin
            target_x_ff <= signed'(rdata_ff[15:0]);
            target_y_ff <= signed'(rdata_ff[31:16]);
         end
         if (cmd.cordic_last) begin
            heading_ff <= czero_ff ? 16'd0 : cang_in;
         end
         if (cmd.finish && status.is_tick) begin
            phase_ff <= ph;
         end
      end
   end

   // response payload register
   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         if (status.is_tick) begin
            out_linear_speed  <= lin;
            out_angular_speed <= ang;
            out_phase         <= ph;
            out_reached       <= reach;
            out_dropped       <= 1'b0;
            out_queued        <= wttd_pkg::QUEUED_W'(count_ff);
         end else begin
            out_linear_speed  <= 16'd0;
            out_angular_speed <= 17'sd0;
            out_phase         <= phase_ff;
            out_reached       <= 1'b0;
            out_dropped       <= fifo_full;
            out_queued        <= fifo_full ? wttd_pkg::QUEUED_W'(count_ff)
                                           : wttd_pkg::QUEUED_W'(count_ff + 1'b1);
         end
      end
   end

endmodule

[rtl/wttd_controller.sv]
// Controller: sequences one request through FIFO read, CORDIC and evaluation.
// Depends on wttd_pkg.
module wttd_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  wttd_pkg::status_type status,
   output wttd_pkg::cmd_type    cmd
);
   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_READ   = 3'd1;
   localparam logic [2:0] S_LOAD   = 3'd2;
   localparam logic [2:0] S_CORDIC = 3'd3;
   localparam logic [2:0] S_SQR    = 3'd4;
   localparam logic [2:0] S_FINISH = 3'd5;

   logic [2:0]                  state_ff, state_in;
   logic [wttd_pkg::STEP_W-1:0] step_ff, step_in;
   logic                        valid_ff, valid_in;
   logic                        slot_free, last_step;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = valid_ff;
   assign slot_free = !valid_ff || rsp_ready;
   assign last_step = (step_ff == wttd_pkg::STEP_W'(wttd_pkg::CORDIC_STEPS - 1));

   // next state and commands
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      valid_in = valid_ff && !rsp_ready;
      cmd      = '0;
      cmd.step = step_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = S_SQR;
            end
         end
         S_SQR: begin
            // reached after latch and after the CORDIC; decides whether a pop is needed
            if (status.is_tick && status.start_pop) begin
               cmd.fifo_read = 1'b1;
               state_in      = S_READ;
            end else if (status.is_tick) begin
               cmd.square = 1'b1;
               state_in   = S_FINISH;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_READ: begin
            state_in = S_LOAD;
         end
         S_LOAD: begin
            cmd.load = 1'b1;
            step_in  = '0;
            state_in = S_CORDIC;
         end
         S_CORDIC: begin
            cmd.cordic_step = 1'b1;
            if (last_step) begin
               cmd.cordic_last = 1'b1;
               state_in        = S_SQR;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         S_FINISH: begin
            if (slot_free) begin
               cmd.finish = 1'b1;
               valid_in   = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         valid_ff <= valid_in;
      end
   end

endmodule

[rtl/waypoint_turn_then_drive_controller_core.sv]
// Top level of the turn-then-drive waypoint follower.
// Depends on wttd_pkg, wttd_if, wttd_controller and wttd_datapath.
//
// Usage:
//   req: valid/ready channel. req_type 0 pushes waypoint (pos_x, pos_y) into a
//        16-entry FIFO; req_type 1 is a pose tick with measured pos and yaw.
//   rsp: one response transfer per request: speeds, phase, reached, dropped
//        and the FIFO fill after the request.
//   csr: APB-style write/read port, register i at byte address 4*i, no waits.
// A push or a tick without a pop goes from the latch through S_SQR and S_FINISH;
// a tick that pops also reads the FIFO, loads the vector and runs the shared
// one-step-per-cycle CORDIC unit. One request is in flight at a time; the
// next is taken the cycle after the response is loaded, even while it still
// waits, so no request is taken before the last one's response is loaded.
// When rsp stalls, the finished response holds and a following request waits
// in the finish step until the output register frees.
// Reset (synchronous) empties the FIFO, sets phase idle and loads the default
// register values; no clearing pass is needed.
module waypoint_turn_then_drive_controller_core (
   input  logic         clock,
   input  logic         reset,
   wttd_req_if.sink     req,
   wttd_rsp_if.source   rsp,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [wttd_pkg::PADDR_W-1:0] csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);
   wttd_pkg::cmd_type    cmd;
   wttd_pkg::status_type status;
   logic                 csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   wttd_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .status    (status),
      .cmd       (cmd)
   );

   wttd_datapath u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .in_type           (req.req_type),
      .in_pos_x          (req.pos_x),
      .in_pos_y          (req.pos_y),
      .in_yaw            (req.pose_yaw),
      .csr_wr            (csr_wr),
      .csr_index         (csr_paddr[4:2]),
      .csr_wdata         (csr_pwdata),
      .csr_rdata         (csr_prdata),
      .out_linear_speed  (rsp.linear_speed),
      .out_angular_speed (rsp.angular_speed),
      .out_phase         (rsp.phase),
      .out_reached       (rsp.reached),
      .out_dropped       (rsp.dropped),
      .out_queued        (rsp.queued)
   );

endmodule

[rtl/wttd_checker.sv]
// Port-level checks on the response channel of the waypoint follower.
// Depends on wttd_pkg; bound to waypoint_turn_then_drive_controller_core.
module wttd_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [15:0]       rsp_linear_speed,
   input logic signed [16:0] rsp_angular_speed,
   input logic [1:0]        rsp_phase,
   input logic              rsp_reached,
   input logic              rsp_dropped,
   input logic [4:0]        rsp_queued
);
   // a stalled response stays valid
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // arrival ends in idle with no motion
   a_reach: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_reached |->
         rsp_phase == wttd_pkg::PH_IDLE && rsp_linear_speed == 16'd0
         && rsp_angular_speed == 17'sd0)
      else $error("reached without stopping");

   // a drop only happens with a full queue
   a_drop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_dropped |->
         rsp_queued == wttd_pkg::QUEUED_W'(wttd_pkg::FIFO_DEPTH))
      else $error("drop with room in queue");

   // forward motion only while driving
   a_drive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_linear_speed != 16'd0 |-> rsp_phase == wttd_pkg::PH_DRIVE)
      else $error("forward speed outside drive phase");

endmodule

bind waypoint_turn_then_drive_controller_core wttd_checker u_chk (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp.valid),
   .rsp_ready         (rsp.ready),
   .rsp_linear_speed  (rsp.linear_speed),
   .rsp_angular_speed (rsp.angular_speed),
   .rsp_phase         (rsp.phase),
   .rsp_reached       (rsp.reached),
   .rsp_dropped       (rsp.dropped),
   .rsp_queued        (rsp.queued)
);

[tb/testbench.sv]
// Self-checking testbench for the turn-then-drive waypoint follower core.
// Depends on wttd_pkg, wttd_if and waypoint_turn_then_drive_controller_core.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic        kind;
      logic [15:0] x;
      logic [15:0] y;
      logic [15:0] yaw;
   } cmd_item_t;

   typedef struct packed {
      logic [15:0] lin;
      logic [16:0] ang;
      logic [1:0]  ph;
      logic        reached;
      logic        dropped;
      logic [4:0]  queued;
   } motion_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [wttd_pkg::PADDR_W-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   wttd_req_if req ();
   wttd_rsp_if rsp ();

   waypoint_turn_then_drive_controller_core dut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // predictor state
   logic [31:0] wp_store [wttd_pkg::FIFO_DEPTH];
   int unsigned wp_head, wp_tail, wp_count;
   logic signed [15:0] tgt_x, tgt_y;
   logic [15:0] tgt_heading;
   logic [1:0] ctl_phase;
   logic [15:0] cfg_drive, cfg_fast, cfg_fine, cfg_radius;
   logic [14:0] cfg_coarse_tol, cfg_fine_tol;

   cmd_item_t pending_cmds [$];
   motion_t expected_motion [$];
   int mismatch_count = 0;
   int stall_mode = 0;
   longint cycle_count = 0;
   logic req_fire_ff = 1'b0;

   function automatic logic [15:0] atan_step(input int i);
      logic [15:0] t [15] = '{16'd8192, 16'd4836, 16'd2555, 16'd1297, 16'd651, 16'd326,
                              16'd163, 16'd81, 16'd41, 16'd20, 16'd10, 16'd5, 16'd3,
                              16'd1, 16'd1};
      return (i < 15) ? t[i] : 16'd0;
   endfunction

   function automatic logic [15:0] heading_to(input longint dy_in, input longint dx_in);
      longint cx, cy, sx, sy;
      logic [15:0] ang;
      cx = dx_in;
      cy = dy_in;
      ang = 16'd0;
      if (cx == 0 && cy == 0) return 16'd0;
      if (cx < 0) begin
         cx = -cx;
         cy = -cy;
         ang = 16'd32768;
      end
      for (int i = 0; i < wttd_pkg::CORDIC_STEPS; i++) begin
         sx = cx >>> i;
         sy = cy >>> i;
         if (cy >= 0) begin
            cx = cx + sy;
            cy = cy - sx;
            ang = ang + atan_step(i);
         end else begin
            cx = cx - sy;
            cy = cy + sx;
            ang = ang - atan_step(i);
         end
      end
      return ang;
   endfunction

   // compute the response to one accepted request
   function automatic motion_t follow_step(input cmd_item_t c);
      motion_t m;
      logic signed [15:0] err;
      int mag, s_lin, s_ang;
      longint ddx, ddy;
      logic [31:0] e;
      s_lin = 0;
      s_ang = 0;
      m = '0;
      if (c.kind == wttd_pkg::REQ_PUSH) begin
         if (wp_count < wttd_pkg::FIFO_DEPTH) begin
            wp_store[wp_tail] = {c.y, c.x};
            wp_tail = (wp_tail + 1) % wttd_pkg::FIFO_DEPTH;
            wp_count++;
         end else m.dropped = 1'b1;
      end else begin
         if (ctl_phase == wttd_pkg::PH_IDLE && wp_count > 0) begin
            e = wp_store[wp_head];
            wp_head = (wp_head + 1) % wttd_pkg::FIFO_DEPTH;
            wp_count--;
            tgt_x = e[15:0];
            tgt_y = e[31:16];
            tgt_heading = heading_to(longint'(tgt_y) - longint'($signed(c.y)),
                                     longint'(tgt_x) - longint'($signed(c.x)));
            ctl_phase = wttd_pkg::PH_COARSE;
         end
         err = tgt_heading - c.yaw;
         mag = (err < 0) ? -int'(err) : int'(err);
         if (ctl_phase == wttd_pkg::PH_COARSE) begin
            if (mag > cfg_coarse_tol) s_ang = (err < 0) ? -int'(cfg_fast) : int'(cfg_fast);
            else ctl_phase = wttd_pkg::PH_FINE;
         end
         if (ctl_phase == wttd_pkg::PH_FINE) begin
            if (mag > cfg_fine_tol) s_ang = (err < 0) ? -int'(cfg_fine) : int'(cfg_fine);
            else ctl_phase = wttd_pkg::PH_DRIVE;
         end
         if (ctl_phase == wttd_pkg::PH_DRIVE) begin
            ddx = longint'(tgt_x) - longint'($signed(c.x));
            ddy = longint'(tgt_y) - longint'($signed(c.y));
            if (ddx * ddx + ddy * ddy > longint'(cfg_radius) * longint'(cfg_radius))
               s_lin = cfg_drive;
            else begin
               m.reached = 1'b1;
               ctl_phase = wttd_pkg::PH_IDLE;
            end
         end
      end
      m.lin = s_lin[15:0];
      m.ang = s_ang[16:0];
      m.ph = ctl_phase;
      m.queued = wp_count[4:0];
      return m;
   endfunction

   // sender: bursts with random gaps
   int burst_left = 0, gap_left = 0;
   logic hold_sender = 1'b0;
   initial begin
      req.valid = 1'b0;
      req.req_type = wttd_pkg::REQ_PUSH;
      req.pos_x = '0;
      req.pos_y = '0;
      req.pose_yaw = '0;
      rsp.ready = 1'b0;
   end

   always @(negedge clock) begin
      if (!reset) begin
         // drop the front item once its transfer happened at the last rising edge
         if (req_fire_ff) begin
            void'(pending_cmds.pop_front());
         end
         if (req_fire_ff || !req.valid) begin
            if (gap_left > 0 || hold_sender || pending_cmds.size() == 0) begin
               if (gap_left > 0) gap_left--;
               req.valid <= 1'b0;
            end else begin
               req.valid <= 1'b1;
               req.req_type <= pending_cmds[0].kind;
               req.pos_x <= pending_cmds[0].x;
               req.pos_y <= pending_cmds[0].y;
               req.pose_yaw <= pending_cmds[0].yaw;
               if (burst_left > 0) burst_left--;
               else begin
                  burst_left = $urandom_range(1, 12);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 30);
               end
            end
         end
         // receiver stall pattern
         case (stall_mode)
            0: rsp.ready <= 1'b1;
            1: rsp.ready <= ($urandom_range(0, 3) != 0);
            2: rsp.ready <= (cycle_count[3:0] < 4'd5);
            default: rsp.ready <= ($urandom_range(0, 9) == 0);
         endcase
         if (cycle_count[8:0] == 9'd0) stall_mode = $urandom_range(0, 3);
      end
   end

   // monitor: predict on request transfers, check on response transfers
   always @(posedge clock) begin
      motion_t got, want;
      cycle_count <= cycle_count + 1;
      req_fire_ff <= !reset && req.valid && req.ready;
      if (!reset) begin
         if (req.valid && req.ready)
            expected_motion.push_back(follow_step({req.req_type, req.pos_x, req.pos_y,
                                                   req.pose_yaw}));
         if (rsp.valid && rsp.ready) begin
            got = {rsp.linear_speed, rsp.angular_speed, rsp.phase, rsp.reached,
                   rsp.dropped, rsp.queued};
            if (expected_motion.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) $display("response with nothing expected: %p", got);
            end else begin
               want = expected_motion.pop_front();
               if (got !== want) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("mismatch: expected %p actual %p", want, got);
               end
            end
         end
      end
   end

   task automatic csr_write(input logic [2:0] idx, input logic [31:0] val);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= wttd_pkg::PADDR_W'(idx) << 2;
      csr_pwdata <= val;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         wttd_pkg::REG_DRIVE_SPEED: cfg_drive = val[15:0];
         wttd_pkg::REG_FAST_RATE:   cfg_fast = val[15:0];
         wttd_pkg::REG_FINE_RATE:   cfg_fine = val[15:0];
         wttd_pkg::REG_COARSE_TOL:  cfg_coarse_tol = val[14:0];
         wttd_pkg::REG_FINE_TOL:    cfg_fine_tol = val[14:0];
         default:                   cfg_radius = val[15:0];
      endcase
   endtask

   task automatic wait_drained();
      while (pending_cmds.size() != 0 || req.valid || expected_motion.size() != 0)
         @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic add_cmd(input logic kind, input logic [15:0] x, input logic [15:0] y,
                          input logic [15:0] yaw);
      pending_cmds.push_back('{kind, x, y, yaw});
   endtask

   function automatic logic [15:0] rand_coord();
      case ($urandom_range(0, 3))
         0: return 16'($urandom_range(0, 4000)) - 16'd2000;
         1: return 16'($urandom);
         2: return ($urandom_range(0, 1)) ? 16'h7FFF : 16'h8000;
         default: return 16'($urandom_range(0, 400)) - 16'd200;
      endcase
   endfunction

   // hops waypoints pushed, then random pose ticks, eight per waypoint
   task automatic add_route(input int hops);
      logic [15:0] rx, ry, yaw;
      rx = rand_coord();
      ry = rand_coord();
      for (int h = 0; h < hops; h++)
         add_cmd(wttd_pkg::REQ_PUSH, rand_coord(), rand_coord(), 16'($urandom));
      for (int t = 0; t < hops * 8; t++) begin
         yaw = 16'($urandom);
         if ($urandom_range(0, 2) == 0) begin
            rx = rand_coord();
            ry = rx;
         end
         add_cmd(wttd_pkg::REQ_TICK, rx, ry, yaw);
      end
   endtask

   initial begin
      cfg_drive = 16'd92; cfg_fast = 16'd82; cfg_fine = 16'd20;
      cfg_coarse_tol = 15'd1043; cfg_fine_tol = 15'd104; cfg_radius = 16'd410;
      wp_head = 0; wp_tail = 0; wp_count = 0;
      tgt_x = '0; tgt_y = '0; tgt_heading = '0; ctl_phase = wttd_pkg::PH_IDLE;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: tick on empty FIFO, extremes, fill past full, zero vector, half turn
      add_cmd(wttd_pkg::REQ_TICK, 16'h8000, 16'h7FFF, 16'h8000);
      add_cmd(wttd_pkg::REQ_PUSH, 16'd100, 16'd100, 16'd0);
      add_cmd(wttd_pkg::REQ_TICK, 16'd100, 16'd100, 16'h8000);
      add_cmd(wttd_pkg::REQ_TICK, 16'd100, 16'd100, 16'd0);
      add_cmd(wttd_pkg::REQ_PUSH, 16'h7FFF, 16'h8000, 16'hFFFF);
      add_cmd(wttd_pkg::REQ_TICK, 16'h8000, 16'h7FFF, 16'h7FFF);
      for (int i = 0; i < 17; i++)
         add_cmd(wttd_pkg::REQ_PUSH, 16'(i * 37), 16'h8000 + 16'(i), 16'd0);
      add_cmd(wttd_pkg::REQ_TICK, 16'h8000, 16'h7FFF, 16'h2000);
      wait_drained();

      // drive to full arrival: zero tolerances rarely met, so use wide ones
      csr_write(wttd_pkg::REG_COARSE_TOL, 32'h7FFF);
      csr_write(wttd_pkg::REG_FINE_TOL, 32'h7FFF);
      csr_write(wttd_pkg::REG_ARRIVE_RAD, 32'hFFFF);
      csr_write(wttd_pkg::REG_DRIVE_SPEED, 32'hFFFF);
      csr_write(wttd_pkg::REG_FAST_RATE, 32'hFFFF);
      csr_write(wttd_pkg::REG_FINE_RATE, 32'hFFFF);
      for (int i = 0; i < 20; i++)
         add_cmd(wttd_pkg::REQ_TICK, 16'($urandom), 16'($urandom), 16'($urandom));
      add_route(3);
      wait_drained();

      // random phases under several register settings
      for (int p = 0; p < 6; p++) begin
         case (p)
            0: begin
               csr_write(wttd_pkg::REG_COARSE_TOL, 32'd0);
               csr_write(wttd_pkg::REG_FINE_TOL, 32'd0);
               csr_write(wttd_pkg::REG_ARRIVE_RAD, 32'd0);
               csr_write(wttd_pkg::REG_DRIVE_SPEED, 32'd0);
               csr_write(wttd_pkg::REG_FAST_RATE, 32'd0);
               csr_write(wttd_pkg::REG_FINE_RATE, 32'd0);
            end
            1: begin
               csr_write(wttd_pkg::REG_COARSE_TOL, 32'd1043);
               csr_write(wttd_pkg::REG_FINE_TOL, 32'd104);
               csr_write(wttd_pkg::REG_ARRIVE_RAD, 32'd410);
               csr_write(wttd_pkg::REG_DRIVE_SPEED, 32'd92);
               csr_write(wttd_pkg::REG_FAST_RATE, 32'd82);
               csr_write(wttd_pkg::REG_FINE_RATE, 32'd20);
            end
            default: begin
               csr_write(wttd_pkg::REG_COARSE_TOL, $urandom);
               csr_write(wttd_pkg::REG_FINE_TOL, $urandom);
               csr_write(wttd_pkg::REG_ARRIVE_RAD, $urandom_range(0, 3000));
               csr_write(wttd_pkg::REG_DRIVE_SPEED, $urandom);
               csr_write(wttd_pkg::REG_FAST_RATE, $urandom);
               csr_write(wttd_pkg::REG_FINE_RATE, $urandom);
            end
         endcase
         for (int r = 0; r < 9; r++) begin
            if ($urandom_range(0, 3) == 0)
               for (int k = 0; k < 5; k++) add_cmd(1'($urandom_range(0, 1)), rand_coord(),
                                                   rand_coord(), 16'($urandom));
            else add_route($urandom_range(1, 2));
         end
         if (p == 3) begin
            hold_sender = 1'b1;
            while (expected_motion.size() != 0 || req.valid) @(posedge clock);
            hold_sender = 1'b0;
         end
         wait_drained();
      end

      if (mismatch_count == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end

   // run limit
   always @(posedge clock) begin
      if (cycle_count > 64'd1000000) begin
         $display("Mismatches found");
         $finish;
      end
   end
endmodule
